/* hw/rtl/utt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Shared transaction types, surrogate constants and the UTF-8 encoder for a
// code point of the basic multilingual plane.
// ----------------------------------------------------------------------------
package utt_pkg;

   // Surrogate ranges and fixed code points
   localparam logic [15:0] SurHighFirst = 16'hD800;
   localparam logic [15:0] SurHighLast  = 16'hDBFF;
   localparam logic [15:0] SurLowFirst  = 16'hDC00;
   localparam logic [15:0] SurLowLast   = 16'hDFFF;
   localparam logic [15:0] Replacement  = 16'hFFFD;
   localparam logic [20:0] SuppBase     = 21'h010000;

   // At most six bytes per input transaction
   localparam int MaxBytes   = 6;
   localparam int CountWidth = $clog2(MaxBytes + 1);

   // Request and response payloads
   typedef struct packed {
      logic [15:0] code_unit_raw;
      logic        last_unit;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   // Encoded bytes of one basic-plane code point, first byte at index 0
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
   } bmp_bytes_type;

   // Byte group handed from the decoder to the serialiser
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [CountWidth-1:0]    count;
   } byte_group_type;

   // UTF-8 encoding of a 16-bit code point: one, two or three bytes.
   function automatic bmp_bytes_type encode_bmp(input logic [15:0] cp);
      bmp_bytes_type res;
      res.bytes = '0;
      if (cp < 16'h0080) begin
         res.bytes[0] = {1'b0, cp[6:0]};
         res.count    = 2'd1;
      end else if (cp < 16'h0800) begin
         res.bytes[0] = {3'b110, cp[10:6]};
         res.bytes[1] = {2'b10, cp[5:0]};
         res.count    = 2'd2;
      end else begin
         res.bytes[0] = {4'b1110, cp[15:12]};
         res.bytes[1] = {2'b10, cp[11:6]};
         res.bytes[2] = {2'b10, cp[5:0]};
         res.count    = 2'd3;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/utt_decode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-16 decoder stage
// Registers one request transaction, pairs surrogates against the held high
// surrogate and produces the complete UTF-8 byte group for the transaction.
// ----------------------------------------------------------------------------
module utt_decode
   import utt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           big_endian,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire req_type        req_payload,
   output logic                group_valid,
   input  wire logic           group_ready,
   output byte_group_type      group
);

   logic          stage_valid_ff, stage_valid_in;
   req_type       stage_ff;
   logic          held_valid_ff, held_valid_in;
   logic [9:0]    held_bits_ff, held_bits_in;
   logic [15:0]   unit;
   logic          is_low, is_high, pair, second_on, retire;
   logic [20:0]   cp_pair;
   bmp_bytes_type second, repl;

   // Byte order of the stream
   assign unit = big_endian ? {stage_ff.code_unit_raw[7:0], stage_ff.code_unit_raw[15:8]}
                            : stage_ff.code_unit_raw;

   assign is_low  = (unit >= SurLowFirst) && (unit <= SurLowLast);
   assign is_high = (unit >= SurHighFirst) && (unit <= SurHighLast);
   assign pair    = held_valid_ff && is_low;

   // A high surrogate at the end of the stream is replaced at once.
   assign second_on = !is_high || stage_ff.last_unit;
   assign second    = encode_bmp(is_high ? Replacement : unit);
   assign repl      = encode_bmp(Replacement);
   assign cp_pair   = SuppBase + {1'b0, held_bits_ff, unit[9:0]};

   // Assemble the byte group: pair, or optional flush then the unit itself.
   always_comb begin
      group.bytes = '0;
      group.count = '0;
      if (pair) begin
         group.bytes[0] = {5'b11110, cp_pair[20:18]};
         group.bytes[1] = {2'b10, cp_pair[17:12]};
         group.bytes[2] = {2'b10, cp_pair[11:6]};
         group.bytes[3] = {2'b10, cp_pair[5:0]};
         group.count    = CountWidth'(4);
      end else if (held_valid_ff) begin
         group.bytes[2:0] = repl.bytes;
         group.bytes[5:3] = second.bytes;
         group.count      = CountWidth'(3)
                            + (second_on ? CountWidth'(second.count) : CountWidth'(0));
      end else begin
         group.bytes[2:0] = second.bytes;
         group.count      = second_on ? CountWidth'(second.count) : CountWidth'(0);
      end
   end

   // A transaction that yields no bytes retires without waiting.
   assign group_valid = stage_valid_ff && (group.count != '0);
   assign retire      = stage_valid_ff && ((group.count == '0) || group_ready);
   assign req_ready   = !stage_valid_ff || retire;

   // Stage occupancy and surrogate hold
   always_comb begin
      stage_valid_in = stage_valid_ff;
      held_valid_in  = held_valid_ff;
      held_bits_in   = held_bits_ff;
      if (retire) begin
         stage_valid_in = 1'b0;
         held_valid_in  = is_high && !stage_ff.last_unit;
         held_bits_in   = held_valid_in ? unit[9:0] : 10'd0;
      end
      if (req_valid && req_ready) begin
         stage_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         held_valid_ff  <= 1'b0;
         held_bits_ff   <= 10'd0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         held_valid_ff  <= held_valid_in;
         held_bits_ff   <= held_bits_in;
      end
   end

   // Request payload register
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_ff <= req_payload;
      end
   end

`ifndef SYNTH
   a_hold_only_high : assert property (@(posedge clock) disable iff (reset)
      (retire && is_high && !stage_ff.last_unit)
      |=> (held_valid_ff && (held_bits_ff == $past(unit[9:0]))))
      else $error("held surrogate bits do not match the unit that set them");
   a_no_silent_drop : assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !is_high) |-> group_valid)
      else $error("non-high unit produced no bytes");
   a_pair_clears : assert property (@(posedge clock) disable iff (reset)
      (retire && pair) |=> !held_valid_ff)
      else $error("surrogate hold not cleared after a pair");
`endif

endmodule
`default_nettype wire

/* hw/rtl/utt_serializer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 byte serialiser
// Holds one byte group and presents it one byte per response transaction,
// marking the final byte of the group.
// ----------------------------------------------------------------------------
module utt_serializer
   import utt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           group_valid,
   output logic                group_ready,
   input  wire byte_group_type group,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output rsp_type             rsp_payload
);

   logic [MaxBytes-1:0][7:0] bytes_ff, bytes_in;
   logic [CountWidth-1:0]    count_ff, count_in;
   logic                     take, load;

   assign rsp_valid             = (count_ff != '0);
   assign take                  = rsp_valid && rsp_ready;
   assign rsp_payload.out_byte  = bytes_ff[0];
   assign rsp_payload.last_byte = (count_ff == CountWidth'(1));

   // A new group may enter as the last byte of the current one leaves.
   assign group_ready = (count_ff == '0) || (rsp_payload.last_byte && rsp_ready);
   assign load        = group_valid && group_ready;

   // Load a group or shift the next byte to the front
   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      if (load) begin
         bytes_in = group.bytes;
         count_in = group.count;
      end else if (take) begin
         bytes_in = {8'h00, bytes_ff[MaxBytes-1:1]};
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

`ifndef SYNTH
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(MaxBytes))
      else $error("byte count exceeds the group size");
   a_step_down : assert property (@(posedge clock) disable iff (reset)
      (take && !rsp_payload.last_byte) |=> (count_ff == $past(count_ff) - CountWidth'(1)))
      else $error("byte count did not step after a transaction");
   a_load_counts : assert property (@(posedge clock) disable iff (reset)
      load |=> (count_ff == $past(group.count)))
      else $error("loaded group count lost");
`endif

endmodule
`default_nettype wire

/* hw/rtl/utf16_to_utf8_transcode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder
// Converts a stream of UTF-16 code units into UTF-8 bytes, pairing
// surrogates and replacing unpaired high surrogates with U+FFFD.
// ----------------------------------------------------------------------------
//  Channel | Ports            | Direction | Contents
//  req     | req_valid/ready  | in        | code_unit_raw, last_unit
//  rsp     | rsp_valid/ready  | out       | out_byte, last_byte
//  csr     | csr_write_enable | in        | big_endian in bit 0
//
// One response byte leaves per cycle while rsp_ready is high; a code unit
// yields 1 to 3 bytes for a basic-plane unit, 4 for a surrogate pair, up to
// 6 with a flushed replacement; a held high surrogate yields no byte.
// A request is registered in the decoder stage and its byte group in the
// serialiser; the decoder stage and the serialiser overlap, so a new
// request enters while bytes still drain.
// Reset is synchronous and clears the surrogate hold and the big-endian mode.
// A stalled response holds its byte; requests back up behind it.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcode
   import utt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload,
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data
);

   logic           big_endian_ff, big_endian_in;
   logic           group_valid, group_ready;
   byte_group_type group;

   // Configuration register
   assign big_endian_in = csr_write_enable ? csr_write_data : big_endian_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
      end else begin
         big_endian_ff <= big_endian_in;
      end
   end

   // Decoder stage with surrogate hold
   utt_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .big_endian  (big_endian_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .group_valid (group_valid),
      .group_ready (group_ready),
      .group       (group)
   );

   // Byte serialiser
   utt_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .group_valid (group_valid),
      .group_ready (group_ready),
      .group       (group),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
